@@ design/mrwt_pkg.sv @@
// Package for the Miller-Rabin witness test block.
// Holds widths, verdict codes and sequencer states; no dependencies.
package mrwt_pkg;
  localparam int unsigned WIDTH = 64;
  localparam int unsigned BIT_W = $clog2(WIDTH);

  typedef enum logic [1:0] {
    VERDICT_COMPOSITE = 2'd0,
    VERDICT_PRIME     = 2'd1,
    VERDICT_INVALID   = 2'd2
  } verdict_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STRIP,
    ST_POW_SQ,
    ST_POW_MUL,
    ST_SQ_LOOP,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mul_ctl_t;
endpackage

@@ design/mrwt_mulmod.sv @@
// Shift-and-add modular multiplier, one operand bit per cycle.
// Depends on mrwt_pkg.
module mrwt_mulmod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mrwt_pkg::WIDTH-1:0] x,
  input  logic [mrwt_pkg::WIDTH-1:0] y,
  input  logic [mrwt_pkg::WIDTH-1:0] m,
  output mrwt_pkg::mul_ctl_t         ctl,
  output logic [mrwt_pkg::WIDTH-1:0] prod
);
  logic [mrwt_pkg::WIDTH-1:0] acc, xr, yr, mr;
  logic [mrwt_pkg::BIT_W-1:0] cnt;
  logic busy, done;
  logic [mrwt_pkg::WIDTH:0] dbl, sum;
  logic [mrwt_pkg::WIDTH-1:0] a1, a2;

  always_comb begin
    dbl = {acc, 1'b0};
    a1 = (dbl >= {1'b0, mr}) ? mrwt_pkg::WIDTH'(dbl - {1'b0, mr})
                             : dbl[mrwt_pkg::WIDTH-1:0];
    sum = {1'b0, a1} + {1'b0, xr};
    a2 = (sum >= {1'b0, mr}) ? mrwt_pkg::WIDTH'(sum - {1'b0, mr})
                             : sum[mrwt_pkg::WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      acc <= '0;
      xr  <= x;
      yr  <= y;
      mr  <= m;
      cnt <= mrwt_pkg::BIT_W'(mrwt_pkg::WIDTH - 1);
    end else if (busy) begin
      acc <= yr[mrwt_pkg::WIDTH-1] ? a2 : a1;
      yr  <= {yr[mrwt_pkg::WIDTH-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

  assign prod = acc;
  assign ctl = '{start: start, busy: busy, done: done};

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("start did not launch");
  assert property (@(posedge clk) disable iff (rst) busy && !start |-> acc < mr)
    else $error("accumulator out of range");
endmodule

@@ design/miller_rabin_witness_test_top.sv @@
// Miller-Rabin witness round: one candidate/witness transaction in, one verdict out.
// Trivial cases go straight to the verdict; otherwise up to about 2*WIDTH modular multiplies
// run one after another on the one shared multiplier.
// Throughput: one transaction at a time; in_ready is low while a round runs.
// Reset: rst synchronous, active high, returns the sequencer to idle, drops any result.
// Depends on mrwt_pkg and mrwt_mulmod.
module miller_rabin_witness_test_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] candidate,
  input  logic [63:0] witness,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  verdict
);
  localparam int unsigned W = mrwt_pkg::WIDTH;

  mrwt_pkg::state_t state, state_next;
  logic [W-1:0] p, a, d, x, e, pm1;
  logic [mrwt_pkg::BIT_W-1:0] bitn;
  logic [1:0] vres;
  logic mstart;
  logic [W-1:0] mx, my, mprod;
  mrwt_pkg::mul_ctl_t mctl;
  logic pow_mul_pending;
  logic [W-1:0] cin, win;

  // Cut inputs to WIDTH bits.
  assign cin = W'(candidate);
  assign win = W'(witness);
  assign pm1 = p - 1'b1;

  mrwt_mulmod u_mul (
    .clk(clk), .rst(rst), .start(mstart),
    .x(mx), .y(my), .m(p), .ctl(mctl), .prod(mprod)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state) inside
      mrwt_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (cin < W'(2) || (cin != W'(2) && !cin[0]) || cin == W'(2) ||
              cin == W'(3) || win == '0 || win >= cin) begin
            state_next = mrwt_pkg::ST_DONE;
          end else begin
            state_next = mrwt_pkg::ST_STRIP;
          end
        end
      end
      mrwt_pkg::ST_STRIP: if (d[0]) state_next = mrwt_pkg::ST_POW_SQ;
      mrwt_pkg::ST_POW_SQ, mrwt_pkg::ST_POW_MUL:
        state_next = mrwt_pkg::ST_WAIT;
      // Keep squaring until the loop exits, then hand over the verdict.
      mrwt_pkg::ST_SQ_LOOP:
        state_next = mstart ? mrwt_pkg::ST_WAIT : mrwt_pkg::ST_DONE;
      mrwt_pkg::ST_WAIT: begin
        if (mctl.done) begin
          if (pow_mul_pending) begin
            if (e[W-1]) state_next = mrwt_pkg::ST_POW_MUL;
            else if (bitn == '0) state_next = mrwt_pkg::ST_SQ_LOOP;
            else state_next = mrwt_pkg::ST_POW_SQ;
          end else if (bitn == '0 && e == '0) begin
            state_next = mrwt_pkg::ST_SQ_LOOP;
          end else begin
            state_next = mrwt_pkg::ST_POW_SQ;
          end
        end
      end
      mrwt_pkg::ST_DONE: if (out_ready) state_next = mrwt_pkg::ST_IDLE;
      default: state_next = mrwt_pkg::ST_IDLE;
    endcase
  end

  // Outputs and multiplier launch.
  always_comb begin
    in_ready  = (state == mrwt_pkg::ST_IDLE);
    out_valid = (state == mrwt_pkg::ST_DONE);
    verdict   = vres;
    mstart    = 1'b0;
    mx        = x;
    my        = x;
    unique case (state)
      mrwt_pkg::ST_POW_SQ: mstart = 1'b1;
      mrwt_pkg::ST_POW_MUL: begin
        mstart = 1'b1;
        my     = a;
      end
      mrwt_pkg::ST_SQ_LOOP: mstart = (d != pm1 && x != W'(1) && x != pm1);
      default: mstart = 1'b0;
    endcase
  end

  // Sequencer registers. e holds the remaining exponent bits, msb first.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrwt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end

    unique case (state)
      mrwt_pkg::ST_IDLE: begin
        p <= cin;
        a <= win;
        d <= cin - 1'b1;
        if (cin < W'(2) || (cin != W'(2) && !cin[0])) begin
          vres <= mrwt_pkg::VERDICT_COMPOSITE;
        end else if (cin == W'(2) || cin == W'(3)) begin
          vres <= mrwt_pkg::VERDICT_PRIME;
        end else begin
          vres <= mrwt_pkg::VERDICT_INVALID;
        end
      end
      mrwt_pkg::ST_STRIP: begin
        if (!d[0]) begin
          d <= d >> 1;
        end else begin
          x    <= W'(1);
          e    <= d;
          bitn <= mrwt_pkg::BIT_W'(W - 1);
        end
      end
      mrwt_pkg::ST_POW_SQ: pow_mul_pending <= 1'b1;
      mrwt_pkg::ST_POW_MUL: begin
        pow_mul_pending <= 1'b0;
        e    <= e << 1;
        // Hold the bit counter at zero once the last exponent bit is consumed.
        if (bitn != '0) bitn <= bitn - 1'b1;
      end
      mrwt_pkg::ST_SQ_LOOP: begin
        pow_mul_pending <= 1'b0;
        if (mstart) begin
          d <= d << 1;
          e <= '0;
          bitn <= '0;
        end else begin
          vres <= (x != pm1 && !d[0]) ? mrwt_pkg::VERDICT_COMPOSITE
                                      : mrwt_pkg::VERDICT_PRIME;
        end
      end
      mrwt_pkg::ST_WAIT: begin
        if (mctl.done) begin
          x <= mprod;
          if (pow_mul_pending && !e[W-1]) begin
            pow_mul_pending <= 1'b0;
            e <= e << 1;
            if (bitn != '0) bitn <= bitn - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("verdict dropped");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("accepting while result pending");
  assert property (@(posedge clk) disable iff (rst) mctl.busy |-> state == mrwt_pkg::ST_WAIT)
    else $error("multiplier busy outside wait");
endmodule

@@ bench/tb_miller_rabin_witness_test_top.sv @@
// Self-checking bench for miller_rabin_witness_test_top: directed table, a back-pressure burst, then random rounds.
// Depends on mrwt_pkg and the block; verdicts come from the directed table or an internal Miller-Rabin predictor.
module tb_miller_rabin_witness_test_top;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned RANDOM_ROUNDS = 90;
  localparam int unsigned QUIET_ROUNDS = 20;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] BIG_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;  // 2^64 - 59

  typedef struct {
    logic [63:0]        cand;
    logic [63:0]        wit;
    bit                 known;
    mrwt_pkg::verdict_t want;
  } probe_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] candidate;
  logic [63:0] witness;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  verdict;

  mrwt_pkg::verdict_t verdict_q[$];     // verdicts still owed by the block, oldest first
  int unsigned mismatches = 0;
  int unsigned verdicts_seen = 0;
  int unsigned rounds_sent = 0;
  int unsigned hold_left = 0;    // receiver hold-off, counted down by the receiver
  bit          quiet = 0;        // no idling on either side once set
  int unsigned cycles = 0;

  miller_rabin_witness_test_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .candidate (candidate),
    .witness   (witness),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .verdict   (verdict)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --- Predictor -----------------------------------------------------------
  function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, x} * {64'd0, y};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1;
    for (int b = 63; b >= 0; b--) begin
      acc = mul_mod(acc, acc, m);
      if (e[b]) acc = mul_mod(acc, base, m);
    end
    return acc;
  endfunction

  function automatic mrwt_pkg::verdict_t predict_verdict(logic [63:0] cand_in,
                                                         logic [63:0] wit_in);
    logic [63:0] keep, p, a, pm1, d, x;
    keep = (mrwt_pkg::WIDTH >= 64) ? ALL_ONES : ((64'd1 << mrwt_pkg::WIDTH) - 64'd1);
    p = cand_in & keep;
    a = wit_in & keep;
    if (p < 2 || (p != 2 && !p[0])) return mrwt_pkg::VERDICT_COMPOSITE;
    if (p == 2 || p == 3) return mrwt_pkg::VERDICT_PRIME;
    if (a == 0 || a >= p) return mrwt_pkg::VERDICT_INVALID;
    pm1 = p - 64'd1;
    d = pm1;
    while (!d[0]) d = d >> 1;
    x = pow_mod(a, d, p);
    while (d != pm1 && x != 64'd1 && x != pm1) begin
      x = mul_mod(x, x, p);
      d = d << 1;
    end
    if (x != pm1 && !d[0]) return mrwt_pkg::VERDICT_COMPOSITE;
    return mrwt_pkg::VERDICT_PRIME;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // --- Sender --------------------------------------------------------------
  // Offer one transaction and hold it until accepted; queue its verdict at acceptance.
  task automatic send_round(logic [63:0] c, logic [63:0] w, bit known,
                            mrwt_pkg::verdict_t want);
    in_valid  <= 1'b1;
    candidate <= c;
    witness   <= w;
    do @(posedge clk); while (!in_ready);
    verdict_q.push_back(known ? want : predict_verdict(c, w));
    rounds_sent++;
    // Drop valid only for an idle burst, so it is never lowered and raised in one step.
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain_verdicts();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Random round: mostly full rounds on odd candidates, the rest trivial or bad witnesses.
  task automatic send_random_round();
    logic [63:0] c, w;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    c = rand64();
    w = rand64();
    if (kind <= 1) begin
      c[0] = 1'b0;                                  // even candidate
    end else if (kind == 2) begin
      c = 64'($urandom_range(0, 3));                // below two, two or three
    end else if (kind == 3) begin
      c[0] = 1'b1;
      c = (c < 5) ? 64'd5 : c;
      w = ($urandom_range(0, 1) == 0) ? 64'd0 : c + (w % (ALL_ONES - c + 64'd1));
    end else begin
      case ($urandom_range(0, 5))
        0: c = BIG_PRIME;
        1: c = 64'd1_000_000_007;
        2: c = 64'd561;                             // Carmichael number
        default: c[0] = 1'b1;
      endcase
      c = (c < 5) ? 64'd5 : c;
      w = (w % (c - 64'd1)) + 64'd1;
    end
    send_round(c, w, 1'b0, mrwt_pkg::VERDICT_COMPOSITE);
  endtask

  // --- Receiver ------------------------------------------------------------
  initial begin
    int unsigned        stall_left;
    mrwt_pkg::verdict_t want;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected verdict %0d with nothing outstanding", verdict);
        end else begin
          want = verdict_q.pop_front();
          if (verdict !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: verdict #%0d expected %0d got %0d",
                       verdicts_seen, want, verdict);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d verdicts outstanding", cycles, verdict_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --- Main sequence -------------------------------------------------------
  initial begin
    probe_t probes[16];
    probes = '{
      '{64'd0,            64'd5,             1'b1, mrwt_pkg::VERDICT_COMPOSITE},
      '{64'd1,            64'd0,             1'b1, mrwt_pkg::VERDICT_COMPOSITE},
      '{64'd4,            64'd3,             1'b1, mrwt_pkg::VERDICT_COMPOSITE},
      '{ALL_ONES - 64'd1, 64'd1,             1'b1, mrwt_pkg::VERDICT_COMPOSITE},
      '{64'd2,            64'd0,             1'b1, mrwt_pkg::VERDICT_PRIME},
      '{64'd2,            ALL_ONES,          1'b1, mrwt_pkg::VERDICT_PRIME},
      '{64'd3,            ALL_ONES,          1'b1, mrwt_pkg::VERDICT_PRIME},
      '{ALL_ONES,         64'd0,             1'b1, mrwt_pkg::VERDICT_INVALID},
      '{64'd7,            64'd7,             1'b1, mrwt_pkg::VERDICT_INVALID},
      '{64'd7,            ALL_ONES,          1'b1, mrwt_pkg::VERDICT_INVALID},
      '{64'd97,           64'd2,             1'b0, mrwt_pkg::VERDICT_COMPOSITE},
      '{64'd561,          64'd2,             1'b0, mrwt_pkg::VERDICT_COMPOSITE},
      '{64'd25,           64'd7,             1'b0, mrwt_pkg::VERDICT_COMPOSITE},
      '{BIG_PRIME,        64'd2,             1'b0, mrwt_pkg::VERDICT_COMPOSITE},
      '{BIG_PRIME,        BIG_PRIME - 64'd1, 1'b0, mrwt_pkg::VERDICT_COMPOSITE},
      '{ALL_ONES,         ALL_ONES - 64'd1,  1'b0, mrwt_pkg::VERDICT_COMPOSITE}
    };

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    candidate <= '0;
    witness   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table: edge values, each early exit and a few full rounds.
    foreach (probes[i])
      send_round(probes[i].cand, probes[i].wit, probes[i].known, probes[i].want);

    // Pause the sender until every outstanding verdict has come back.
    drain_verdicts();

    // Hold the receiver off while quick rounds keep coming, so the block backs up.
    hold_left = HOLD_CYCLES;
    repeat (4) send_round(rand64() & ~64'd1, rand64(), 1'b0, mrwt_pkg::VERDICT_COMPOSITE);

    for (int unsigned n = 0; n < RANDOM_ROUNDS; n++) begin
      if (n == RANDOM_ROUNDS - QUIET_ROUNDS) quiet = 1;
      send_random_round();
    end

    drain_verdicts();
    repeat (50) @(posedge clk);

    $display("covered %0d transactions: directed table, back-pressure, random full rounds",
             rounds_sent);
    $display("%0d verdicts checked, %0d mismatches, %0d cycles",
             verdicts_seen, mismatches, cycles);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
